// ----- rtl/max_frequency_within_increment_budget_unit_defines.svh -----
// assertion macros used by the top-level rtl file
`ifndef MAX_FREQUENCY_WITHIN_INCREMENT_BUDGET_UNIT_DEFINES_SVH
`define MAX_FREQUENCY_WITHIN_INCREMENT_BUDGET_UNIT_DEFINES_SVH

// clocked check, quiet while reset is applied
`define MFB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define MFB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/mfb_pkg.sv -----
// shared constants, request types and store control struct
`default_nettype none
package mfb_pkg;
    localparam int DEPTH      = 1024;
    localparam int VALUE_BITS = 16;
    localparam int ADDR_BITS  = $clog2(DEPTH);
    localparam int CNT_BITS   = ADDR_BITS + 1;
    localparam int COST_BITS  = 40;
    localparam int PROD_BITS  = VALUE_BITS + CNT_BITS;
    localparam int BUDGET_BITS = 32;
    localparam int FREQ_BITS  = 11;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  last;
    } in_req_t;

    typedef struct packed {
        logic [FREQ_BITS-1:0] max_frequency;
        logic                 overflow;
    } out_req_t;

    typedef struct packed {
        logic                  we;
        logic [ADDR_BITS-1:0]  waddr;
        logic [VALUE_BITS-1:0] wdata;
        logic [ADDR_BITS-1:0]  raddr_a;
        logic [ADDR_BITS-1:0]  raddr_b;
    } store_ctl_t;
endpackage
`default_nettype wire

// ----- rtl/mfb_store.sv -----
// value store: one write port, two registered read ports
`default_nettype none
module mfb_store
    import mfb_pkg::*;
(
    input  wire logic                  clk,
    input  wire store_ctl_t            ctl,
    output logic [VALUE_BITS-1:0]      rdata_a,
    output logic [VALUE_BITS-1:0]      rdata_b
);
    logic [VALUE_BITS-1:0] mem [DEPTH];

    // write and synchronous reads
    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[ctl.waddr] <= ctl.wdata;
        end
        rdata_a <= mem[ctl.raddr_a];
        rdata_b <= mem[ctl.raddr_b];
    end
endmodule
`default_nettype wire

// ----- rtl/max_frequency_within_increment_budget_unit.sv -----
// top level: load, in-memory insertion sort, sliding window scan
// Values are loaded at one request per cycle into a 1024-entry store; requests past
// capacity are dropped and flag overflow. On the last request the block stops taking
// input, insertion-sorts the store in place and then scans a sliding window over the
// sorted values, each step waiting on the registered read ports of the store. One
// result is offered at the end; input is taken again once it has been accepted.
`default_nettype none
`include "max_frequency_within_increment_budget_unit_defines.svh"
module max_frequency_within_increment_budget_unit
    import mfb_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire in_req_t                in_data,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output out_req_t                    out_data,
    input  wire logic                   cfg_we,
    input  wire logic [BUDGET_BITS-1:0] cfg_data
);
    typedef enum logic [12:0] {
        LOAD    = 13'b0000000000001,
        S_OUTER = 13'b0000000000010,
        S_KEY   = 13'b0000000000100,
        S_IRD   = 13'b0000000001000,
        S_ICMP  = 13'b0000000010000,
        C_INIT  = 13'b0000000100000,
        C_P0    = 13'b0000001000000,
        C_RD    = 13'b0000010000000,
        C_MUL   = 13'b0000100000000,
        C_ADD   = 13'b0001000000000,
        C_CHK   = 13'b0010000000000,
        C_LRD   = 13'b0100000000000,
        OUT     = 13'b1000000000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [BUDGET_BITS-1:0] budget_reg;
    logic [CNT_BITS-1:0]    count_reg, count_next;
    logic                   ovf_reg, ovf_next;
    logic [CNT_BITS-1:0]    i_reg, i_next, j_reg, j_next;
    logic [VALUE_BITS-1:0]  key_reg, key_next;
    logic [CNT_BITS-1:0]    left_reg, left_next, right_reg, right_next;
    logic [VALUE_BITS-1:0]  prev_reg, prev_next, vr_reg, vr_next, vl_reg, vl_next;
    logic [PROD_BITS-1:0]   prod_reg, prod_next;
    logic [COST_BITS-1:0]   cost_reg, cost_next;
    logic [FREQ_BITS-1:0]   best_reg, best_next;
    logic [CNT_BITS-1:0]    j_dec, win_len;
    logic [VALUE_BITS-1:0]  rdata_a, rdata_b;
    store_ctl_t             ctl;
    logic                   acc;

    mfb_store u_store
    (
        .clk     (clk),
        .ctl     (ctl),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    assign acc       = in_valid && !in_stall;
    assign in_stall  = (state_reg != LOAD);
    assign out_valid = (state_reg == OUT);
    assign out_data  = '{max_frequency: best_reg, overflow: ovf_reg};
    assign j_dec     = j_reg - CNT_BITS'(1);
    assign win_len   = right_reg - left_reg + CNT_BITS'(1);

    // budget register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg <= '0;
        end
        else if (cfg_we)
        begin
            budget_reg <= cfg_data;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        key_next   = key_reg;
        left_next  = left_reg;
        right_next = right_reg;
        prev_next  = prev_reg;
        vr_next    = vr_reg;
        vl_next    = vl_reg;
        prod_next  = prod_reg;
        cost_next  = cost_reg;
        best_next  = best_reg;
        ctl        = '{we: 1'b0, waddr: '0, wdata: '0, raddr_a: '0, raddr_b: '0};
        case (state_reg)
            LOAD:
            begin
                if (acc)
                begin
                    if (count_reg < CNT_BITS'(DEPTH))
                    begin
                        ctl.we     = 1'b1;
                        ctl.waddr  = count_reg[ADDR_BITS-1:0];
                        ctl.wdata  = in_data.value;
                        count_next = count_reg + CNT_BITS'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (in_data.last)
                    begin
                        i_next     = CNT_BITS'(1);
                        state_next = S_OUTER;
                    end
                end
            end
            S_OUTER:
            begin
                if (i_reg >= count_reg)
                begin
                    state_next = C_INIT;
                end
                else
                begin
                    ctl.raddr_a = i_reg[ADDR_BITS-1:0];
                    state_next  = S_KEY;
                end
            end
            S_KEY:
            begin
                key_next   = rdata_a;
                j_next     = i_reg;
                state_next = S_IRD;
            end
            S_IRD:
            begin
                if (j_reg == '0)
                begin
                    ctl.we     = 1'b1;
                    ctl.waddr  = j_reg[ADDR_BITS-1:0];
                    ctl.wdata  = key_reg;
                    i_next     = i_reg + CNT_BITS'(1);
                    state_next = S_OUTER;
                end
                else
                begin
                    ctl.raddr_a = j_dec[ADDR_BITS-1:0];
                    state_next  = S_ICMP;
                end
            end
            S_ICMP:
            begin
                ctl.we    = 1'b1;
                ctl.waddr = j_reg[ADDR_BITS-1:0];
                if (rdata_a > key_reg)
                begin
                    ctl.wdata  = rdata_a;
                    j_next     = j_dec;
                    state_next = S_IRD;
                end
                else
                begin
                    ctl.wdata  = key_reg;
                    i_next     = i_reg + CNT_BITS'(1);
                    state_next = S_OUTER;
                end
            end
            C_INIT:
            begin
                cost_next   = '0;
                best_next   = FREQ_BITS'(1);
                left_next   = '0;
                right_next  = CNT_BITS'(1);
                ctl.raddr_a = '0;
                state_next  = C_P0;
            end
            C_P0:
            begin
                prev_next  = rdata_a;
                state_next = C_RD;
            end
            C_RD:
            begin
                if (right_reg >= count_reg)
                begin
                    state_next = OUT;
                end
                else
                begin
                    ctl.raddr_a = right_reg[ADDR_BITS-1:0];
                    ctl.raddr_b = left_reg[ADDR_BITS-1:0];
                    state_next  = C_MUL;
                end
            end
            C_MUL:
            begin
                vr_next    = rdata_a;
                vl_next    = rdata_b;
                prod_next  = PROD_BITS'(rdata_a - prev_reg) * PROD_BITS'(right_reg - left_reg);
                state_next = C_ADD;
            end
            C_ADD:
            begin
                cost_next  = cost_reg + COST_BITS'(prod_reg);
                state_next = C_CHK;
            end
            C_CHK:
            begin
                if (cost_reg > COST_BITS'(budget_reg))
                begin
                    cost_next   = cost_reg - COST_BITS'(vr_reg - vl_reg);
                    left_next   = left_reg + CNT_BITS'(1);
                    ctl.raddr_b = left_next[ADDR_BITS-1:0];
                    state_next  = C_LRD;
                end
                else
                begin
                    if (FREQ_BITS'(win_len) > best_reg)
                    begin
                        best_next = FREQ_BITS'(win_len);
                    end
                    prev_next  = vr_reg;
                    right_next = right_reg + CNT_BITS'(1);
                    state_next = C_RD;
                end
            end
            C_LRD:
            begin
                vl_next    = rdata_b;
                state_next = C_CHK;
            end
            OUT:
            begin
                if (!out_stall)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    cost_next  = '0;
                    state_next = LOAD;
                end
            end
            default:
            begin
                state_next = LOAD;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            cost_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            cost_reg  <= cost_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        i_reg     <= i_next;
        j_reg     <= j_next;
        key_reg   <= key_next;
        left_reg  <= left_next;
        right_reg <= right_next;
        prev_reg  <= prev_next;
        vr_reg    <= vr_next;
        vl_reg    <= vl_next;
        prod_reg  <= prod_next;
        best_reg  <= best_next;
    end

    // checks
    `MFB_ASSERT(a_left_not_past_right, (state_reg == C_CHK) |-> (left_reg <= right_reg),
        "window left edge passed right edge")
    `MFB_ASSERT(a_full_sets_overflow, (acc && (count_reg == CNT_BITS'(DEPTH))) |=> ovf_reg,
        "request at full store did not flag overflow")
    `MFB_ASSERT(a_clear_after_result, (out_valid && !out_stall) |=> (count_reg == '0),
        "store count not cleared after result")
    `MFB_ASSERT(a_sort_index, (state_reg == S_IRD) |-> (j_reg <= i_reg),
        "insertion index beyond key position")
    `MFB_ASSERT_ALWAYS(a_no_input_while_busy, !(out_valid && !in_stall),
        "input open while a result is offered")
endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// testbench for the most-frequent-value unit: directed table, a full-store set, then random data sets
`default_nettype none
module tb;
    import mfb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  SET_ITEMS   = 1950;
    localparam int  CYCLE_LIMIT = 6000000;
    localparam int  SETTLE      = 40;

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_stall;
    in_req_t        in_data;
    logic           out_valid;
    logic           out_stall;
    out_req_t       out_data;
    logic           cfg_we;
    logic [BUDGET_BITS-1:0] cfg_data;

    max_frequency_within_increment_budget_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    // directed stimulus row
    typedef struct {
        bit                    wr_budget;
        bit [BUDGET_BITS-1:0]  budget;
        bit [VALUE_BITS-1:0]   value;
        bit                    last;
        bit                    typed;
        bit [FREQ_BITS-1:0]    freq;
        bit                    ovf;
    } row_t;

    // predictor state
    bit [VALUE_BITS-1:0]   set_vals[$];
    bit                    set_dropped;
    bit [BUDGET_BITS-1:0]  budget_reg;
    out_req_t              result_q[$];

    int  send_pct;
    int  recv_pct;
    int  hold_req;
    int  hold_seen;
    int  hold_cnt;
    int  errors;
    int  cycles;
    int  items_sent;

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // largest window of equal values reachable within the increment budget
    function automatic bit [FREQ_BITS-1:0] best_group(input bit [VALUE_BITS-1:0] vals[$],
                                                       input bit [BUDGET_BITS-1:0] bud);
        bit [VALUE_BITS-1:0] s[$];
        longint unsigned     cost;
        int                  lft;
        int                  best;
        s = vals;
        s.sort();
        cost = 0;
        lft = 0;
        best = 1;
        for (int r = 1; r < s.size(); r++)
        begin
            cost += longint'(s[r] - s[r-1]) * longint'(r - lft);
            while (cost > longint'(bud))
            begin
                cost -= longint'(s[r] - s[lft]);
                lft++;
            end
            if (r - lft + 1 > best)
                best = r - lft + 1;
        end
        return best[FREQ_BITS-1:0];
    endfunction

    // receiver stall, with a long hold-off on request
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_cnt  <= 0;
            hold_seen <= 0;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_cnt  <= 3000;
            out_stall <= 1'b1;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt  <= hold_cnt - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_pct);
    end

    // result check against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (result_q.size() == 0)
            begin
                $display("%0t: unexpected result freq=%0d ovf=%0b", $time,
                         out_data.max_frequency, out_data.overflow);
                errors++;
            end
            else
            begin
                if (out_data.max_frequency !== result_q[0].max_frequency)
                begin
                    $display("%0t: max_frequency expected %0d actual %0d", $time,
                             result_q[0].max_frequency, out_data.max_frequency);
                    errors++;
                end
                if (out_data.overflow !== result_q[0].overflow)
                begin
                    $display("%0t: overflow expected %0b actual %0b", $time,
                             result_q[0].overflow, out_data.overflow);
                    errors++;
                end
                void'(result_q.pop_front());
            end
        end
    end

    // offer one request, called and returning at a falling edge
    task automatic send_value(input bit [VALUE_BITS-1:0] v, input bit l,
                              input bit typed = 0, input out_req_t typed_res = '0);
        out_req_t res;
        while ($urandom_range(0, 99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        in_data.value <= v;
        in_data.last  <= l;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        if (set_vals.size() < DEPTH)
            set_vals.push_back(v);
        else
            set_dropped = 1'b1;
        if (l)
        begin
            res.max_frequency = best_group(set_vals, budget_reg);
            res.overflow      = set_dropped;
            result_q.push_back(typed ? typed_res : res);
            set_vals.delete();
            set_dropped = 1'b0;
        end
        @(negedge clk);
    endtask

    // stop offering, let every result drain, then let the block settle
    task automatic drain;
        in_valid <= 1'b0;
        while (result_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // write the budget register while the block is idle
    task automatic write_budget(input bit [BUDGET_BITS-1:0] b);
        drain();
        cfg_we     <= 1'b1;
        cfg_data   <= b;
        budget_reg  = b;
        @(negedge clk);
        cfg_we     <= 1'b0;
    endtask

    // one data set of random content
    task automatic send_set(input int n, input int mode);
        bit [VALUE_BITS-1:0] base;
        bit [VALUE_BITS-1:0] v;
        base = VALUE_BITS'($urandom);
        for (int i = 0; i < n; i++)
        begin
            case (mode)
                0: v = VALUE_BITS'($urandom);
                1: v = VALUE_BITS'(base + $urandom_range(0, 15));
                2: v = base;
                default: v = $urandom_range(0, 1) ? '1 : '0;
            endcase
            send_value(v, i == n - 1);
        end
    endtask

    // full store plus dropped requests, ascending so the sort stays short
    task automatic send_full_set(input int extra);
        bit [VALUE_BITS-1:0] vals[$];
        for (int i = 0; i < DEPTH + extra; i++)
            vals.push_back(VALUE_BITS'($urandom));
        vals.sort();
        for (int i = 0; i < DEPTH + extra; i++)
            send_value(vals[i], i == DEPTH + extra - 1);
    endtask

    row_t dir_rows[$];
    out_req_t tr;
    int set_no;

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_we      = 1'b0;
        cfg_data    = '0;
        budget_reg  = '0;
        set_dropped = 1'b0;
        send_pct    = 0;
        recv_pct    = 0;
        hold_req    = 0;
        errors      = 0;
        cycles      = 0;
        items_sent  = 0;

        // directed table
        dir_rows = '{
            '{0, 0, 16'd5,     1, 1, 11'd1, 0},
            '{0, 0, 16'hFFFF,  0, 0, 0, 0},
            '{0, 0, 16'hFFFF,  1, 1, 11'd2, 0},
            '{0, 0, 16'h0000,  0, 0, 0, 0},
            '{0, 0, 16'hFFFF,  1, 1, 11'd1, 0},
            '{0, 0, 16'h0000,  1, 1, 11'd1, 0},
            '{1, 32'hFFFFFFFF, 16'h0000, 0, 0, 0, 0},
            '{0, 0, 16'hFFFF,  1, 1, 11'd2, 0},
            '{0, 0, 16'h1234,  0, 0, 0, 0},
            '{0, 0, 16'h0001,  0, 0, 0, 0},
            '{0, 0, 16'h8000,  1, 1, 11'd3, 0},
            '{1, 32'd3,        16'd1, 0, 0, 0, 0},
            '{0, 0, 16'd2,     0, 0, 0, 0},
            '{0, 0, 16'd4,     0, 0, 0, 0},
            '{0, 0, 16'd9,     1, 0, 0, 0},
            '{0, 0, 16'd7,     0, 0, 0, 0},
            '{0, 0, 16'd7,     0, 0, 0, 0},
            '{0, 0, 16'd8,     0, 0, 0, 0},
            '{0, 0, 16'd3,     1, 0, 0, 0},
            '{1, 32'd0,        16'd10, 0, 0, 0, 0},
            '{0, 0, 16'd10,    0, 0, 0, 0},
            '{0, 0, 16'd11,    1, 1, 11'd2, 0}
        };

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].wr_budget)
                write_budget(dir_rows[i].budget);
            tr.max_frequency = dir_rows[i].freq;
            tr.overflow      = dir_rows[i].ovf;
            send_value(dir_rows[i].value, dir_rows[i].last, dir_rows[i].typed, tr);
        end

        // full store with dropped requests, last one dropped too
        write_budget(32'd100000);
        send_full_set(5);

        // random sets across budgets and idling phases
        set_no = 0;
        while (items_sent < SET_ITEMS)
        begin
            if (set_no % 8 == 0)
            begin
                case ($urandom_range(0, 4))
                    0: write_budget('0);
                    1: write_budget('1);
                    2: write_budget($urandom_range(0, 200));
                    3: write_budget($urandom_range(0, 5000));
                    default: write_budget($urandom);
                endcase
                case ((set_no / 8) % 5)
                    0: begin send_pct = 0;  recv_pct = 0;  end
                    1: begin send_pct = 65; recv_pct = 0;  end
                    2: begin send_pct = 0;  recv_pct = 65; end
                    3: begin send_pct = 34; recv_pct = 34; end
                    default: begin send_pct = 0; recv_pct = 0; end
                endcase
            end
            // long receiver hold-off while the sender keeps offering
            if (set_no == 20)
                hold_req++;
            send_set(($urandom_range(0, 5) == 0) ? $urandom_range(1, 3)
                                                  : $urandom_range(2, 30),
                     $urandom_range(0, 3));
            set_no++;
        end

        // end of run
        in_valid <= 1'b0;
        while (result_q.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire
